@@ rtl/adnlp_pkg.sv @@
// Package for the adaptive-degree next-line prefetcher.
// Holds the shared constants, register index codes and the payload and control structs.
// No dependencies; every other file refers to it by scoped names.
package adnlp_pkg;

  // Geometry of blocks and pages, and the range of degrees that get sampled.
  localparam int BLOCK_BITS  = 6;
  localparam int PAGE_BITS   = 12;
  localparam int TOP_DEGREE  = 4;
  localparam int MAX_RESULTS = 4;

  // Field widths.
  localparam int ADDR_W  = 64;
  localparam int CNT_W   = 64;
  localparam int DEG_W   = 3;
  localparam int LIMIT_W = 32;
  localparam int GATE_W  = 16;
  localparam int IDX_W   = $clog2(TOP_DEGREE + 1);
  localparam int EMIT_W  = $clog2(MAX_RESULTS + 2);

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Byte distance between neighboring blocks.
  localparam logic [ADDR_W-1:0] BLOCK_BYTES = ADDR_W'(1) << BLOCK_BITS;

  // Command codes of an input transaction.
  localparam logic CMD_ACCESS = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLE_LIMIT = 2'd0,
    CFG_HOLD_LIMIT   = 2'd1,
    CFG_ACCESS_GATE  = 2'd2
  } cfg_idx_t;

  // Register values after reset.
  localparam logic [LIMIT_W-1:0] SAMPLE_LIMIT_RST = 32'd2048;
  localparam logic [LIMIT_W-1:0] HOLD_LIMIT_RST   = 32'd8388608;
  localparam logic [GATE_W-1:0]  ACCESS_GATE_RST  = 16'd10;

  // Input transaction payload.
  typedef struct packed {
    logic              cmd;
    logic [ADDR_W-1:0] access_addr;
    logic [CNT_W-1:0]  cycle_now;
    logic [CNT_W-1:0]  retired_now;
  } in_t;

  // Result transaction payload.
  typedef struct packed {
    logic [ADDR_W-1:0] prefetch_addr;
    logic              last;
  } out_t;

  // Configuration registers as one group.
  typedef struct packed {
    logic [LIMIT_W-1:0] sample_instr_limit;
    logic [LIMIT_W-1:0] hold_instr_limit;
    logic [GATE_W-1:0]  access_gate;
  } cfg_t;

  // Request to the address emitter.
  typedef struct packed {
    logic              start;
    logic [DEG_W-1:0]  degree;
    logic [ADDR_W-1:0] addr;
  } emit_req_t;

  // Request to the degree tuner.
  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] cycle_now;
    logic [CNT_W-1:0] retired_now;
  } tune_req_t;

endpackage

@@ rtl/adaptive_degree_next_line_prefetcher_core.sv @@
// Top level of the adaptive-degree next-line prefetcher.
// Holds the configuration registers and the access counter; depends on adnlp_pkg,
// adnlp_emit and adnlp_tune.
// Usage:
//   Input channel (in_valid/in_ready/in_data): each transaction is an access (cmd 0)
//   with a byte address, or a tick (cmd 1) carrying the cycle and retired counters.
//   Output channel (out_valid/out_ready/out_data): prefetch block addresses, the
//   final one of each access flagged by last. Ticks give no output.
//   Configuration: cfg_we with cfg_index and cfg_wdata writes a register; idle only.
// Timing:
//   An access first sets the walk active; its addresses then enter the result register
//   one per cycle while out_ready is high. The input is busy while the walk is active,
//   also when the first block already leaves the page, and not at all when the degree is zero.
//   A tick held back by the access gate leaves the input free. A tick that passes the gate
//   keeps the input busy while it is evaluated, and also through the scan when it
//   closes the last sampling window: every stored window after the first goes through the
//   shared 32x32 multiplier, eight partial products per comparison.
// Reset (rst, synchronous): registers return to their defaults, sampling restarts at
//   degree 0 and no output is pending. When out_ready is low the result register holds
//   its transaction and the walk pauses; the next input is taken once the last address
//   of the current access sits in the result register, or the walk stops at the page.
module adaptive_degree_next_line_prefetcher_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  adnlp_pkg::in_t                   in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output adnlp_pkg::out_t                  out_data,
  input  logic                             cfg_we,
  input  logic [adnlp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [adnlp_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  adnlp_pkg::cfg_t                   cfg;
  logic [adnlp_pkg::GATE_W-1:0]      access_count;
  logic                              in_fire;
  logic                              is_tick;
  logic                              gate_open;
  logic                              tune_busy;
  logic                              emit_busy;
  logic [adnlp_pkg::DEG_W-1:0]       cur_degree;
  adnlp_pkg::emit_req_t              emit_req;
  adnlp_pkg::tune_req_t              tune_req;

  // Input handshake and dispatch of the two commands.
  assign in_ready  = !tune_busy && !emit_busy;
  assign in_fire   = in_valid && in_ready;
  assign is_tick   = (in_data.cmd == adnlp_pkg::CMD_TICK);
  assign gate_open = (access_count >= cfg.access_gate);

  always_comb begin
    emit_req.start       = in_fire && !is_tick;
    emit_req.degree      = cur_degree;
    emit_req.addr        = in_data.access_addr;
    tune_req.start       = in_fire && is_tick && gate_open;
    tune_req.cycle_now   = in_data.cycle_now;
    tune_req.retired_now = in_data.retired_now;
  end

  // Configuration registers; an unknown index is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sample_instr_limit <= adnlp_pkg::SAMPLE_LIMIT_RST;
      cfg.hold_instr_limit   <= adnlp_pkg::HOLD_LIMIT_RST;
      cfg.access_gate        <= adnlp_pkg::ACCESS_GATE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        adnlp_pkg::CFG_SAMPLE_LIMIT: begin
          cfg.sample_instr_limit <= cfg_wdata[adnlp_pkg::LIMIT_W-1:0];
        end
        adnlp_pkg::CFG_HOLD_LIMIT: begin
          cfg.hold_instr_limit <= cfg_wdata[adnlp_pkg::LIMIT_W-1:0];
        end
        adnlp_pkg::CFG_ACCESS_GATE: begin
          cfg.access_gate <= cfg_wdata[adnlp_pkg::GATE_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Saturating access counter, cleared by a tick that passes the gate.
  always_ff @(posedge clk) begin
    if (rst) begin
      access_count <= '0;
    end else if (emit_req.start && (access_count != '1)) begin
      access_count <= access_count + adnlp_pkg::GATE_W'(1);
    end else if (tune_req.start) begin
      access_count <= '0;
    end
  end

  adnlp_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .req       (emit_req),
    .busy      (emit_busy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  adnlp_tune u_tune (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .req        (tune_req),
    .busy       (tune_busy),
    .cur_degree (cur_degree)
  );

endmodule

@@ rtl/adnlp_xmul.sv @@
// Shared cross-multiply compare unit: decides whether bn/bd exceeds an/ad exactly.
// Uses one 32x32 multiplier over eight partial products; depends on adnlp_pkg.
// Operands must stay stable from start until done.
module adnlp_xmul (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [adnlp_pkg::CNT_W-1:0] bn,
  input  logic [adnlp_pkg::CNT_W-1:0] bd,
  input  logic [adnlp_pkg::CNT_W-1:0] an,
  input  logic [adnlp_pkg::CNT_W-1:0] ad,
  output logic                        done,
  output logic                        greater
);

  localparam int HALF_W = adnlp_pkg::CNT_W / 2;
  localparam int ACC_W  = 2 * adnlp_pkg::CNT_W + 1;

  logic                              running;
  logic [3:0]                        step;
  logic [adnlp_pkg::CNT_W-1:0]       pp;
  logic [1:0]                        pp_shift;
  logic                              pp_neg;
  logic                              pp_vld;
  logic signed [ACC_W-1:0]           acc;
  logic [adnlp_pkg::CNT_W-1:0]       x_op;
  logic [adnlp_pkg::CNT_W-1:0]       y_op;
  logic [HALF_W-1:0]                 x_half;
  logic [HALF_W-1:0]                 y_half;
  logic [ACC_W-1:0]                  pp_ext;

  // Step bit 2 picks the product (bn*ad added, an*bd subtracted), bits 1:0 the halves.
  always_comb begin
    x_op   = step[2] ? an : bn;
    y_op   = step[2] ? bd : ad;
    x_half = step[0] ? x_op[adnlp_pkg::CNT_W-1:HALF_W] : x_op[HALF_W-1:0];
    y_half = step[1] ? y_op[adnlp_pkg::CNT_W-1:HALF_W] : y_op[HALF_W-1:0];
    pp_ext = ACC_W'(pp) << (HALF_W * int'(pp_shift));
  end

  // The difference of the two products is positive exactly when bn/bd is larger.
  assign greater = !acc[ACC_W-1] && (acc != '0);

  // Multiply one half pair per cycle, accumulate it the cycle after.
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      step    <= '0;
      pp_vld  <= 1'b0;
      done    <= 1'b0;
    end else begin
      if (start) begin
        running <= 1'b1;
        step    <= '0;
        pp_vld  <= 1'b0;
        acc     <= '0;
        done    <= 1'b0;
      end else if (running) begin
        if (step < 4'd8) begin
          pp       <= adnlp_pkg::CNT_W'(x_half) * adnlp_pkg::CNT_W'(y_half);
          pp_shift <= 2'(step[0]) + 2'(step[1]);
          pp_neg   <= step[2];
          pp_vld   <= 1'b1;
          step     <= step + 4'd1;
          done     <= 1'b0;
        end else begin
          pp_vld  <= 1'b0;
          running <= 1'b0;
          done    <= 1'b1;
        end
        if (pp_vld) begin
          if (pp_neg) begin
            acc <= acc - signed'(pp_ext);
          end else begin
            acc <= acc + signed'(pp_ext);
          end
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/adnlp_tune.sv @@
// Degree tuner: evaluates ticks, records per-degree IPC windows and picks the best degree.
// Holds the window marks, the current degree, the sample store and a small sequencer.
// Depends on adnlp_pkg and adnlp_xmul.
module adnlp_tune (
  input  logic                        clk,
  input  logic                        rst,
  input  adnlp_pkg::cfg_t             cfg,
  input  adnlp_pkg::tune_req_t        req,
  output logic                        busy,
  output logic [adnlp_pkg::DEG_W-1:0] cur_degree
);

  typedef enum logic [2:0] {
    T_IDLE,
    T_EVAL,
    T_READ,
    T_LOAD,
    T_MUL
  } state_t;

  state_t                            state;
  logic [adnlp_pkg::CNT_W-1:0]       cyc_q;
  logic [adnlp_pkg::CNT_W-1:0]       ret_q;
  logic [adnlp_pkg::CNT_W-1:0]       mark_retired;
  logic [adnlp_pkg::CNT_W-1:0]       mark_cycle;
  logic                              hold_mode;
  logic [adnlp_pkg::IDX_W-1:0]       cmp_idx;
  logic [adnlp_pkg::IDX_W-1:0]       best;
  logic [adnlp_pkg::CNT_W-1:0]       best_n;
  logic [adnlp_pkg::CNT_W-1:0]       best_d;
  logic [adnlp_pkg::CNT_W-1:0]       rd_n;
  logic [adnlp_pkg::CNT_W-1:0]       rd_d;
  logic [adnlp_pkg::CNT_W-1:0]       sample_n [adnlp_pkg::TOP_DEGREE+1];
  logic [adnlp_pkg::CNT_W-1:0]       sample_d [adnlp_pkg::TOP_DEGREE+1];

  logic [adnlp_pkg::CNT_W-1:0]       rdiff;
  logic [adnlp_pkg::CNT_W-1:0]       cdiff;
  logic [adnlp_pkg::CNT_W-1:0]       limit;
  logic                              window_end;
  logic [adnlp_pkg::IDX_W-1:0]       slot;
  logic [adnlp_pkg::CNT_W-1:0]       norm_n;
  logic [adnlp_pkg::CNT_W-1:0]       norm_d;
  logic                              sample_wr;
  logic                              cmp_start;
  logic                              cmp_done;
  logic                              cmp_greater;

  // Window lengths since the last mark and the slot of the degree under test.
  always_comb begin
    rdiff      = ret_q - mark_retired;
    cdiff      = cyc_q - mark_cycle;
    limit      = hold_mode ? adnlp_pkg::CNT_W'(cfg.hold_instr_limit)
                           : adnlp_pkg::CNT_W'(cfg.sample_instr_limit);
    window_end = rdiff >= limit;
    slot       = (cur_degree > adnlp_pkg::DEG_W'(adnlp_pkg::TOP_DEGREE))
                 ? adnlp_pkg::IDX_W'(adnlp_pkg::TOP_DEGREE)
                 : adnlp_pkg::IDX_W'(cur_degree);
  end

  // A window with no cycles is stored as infinite IPC, or as zero when it has no instructions.
  always_comb begin
    if (cdiff == '0) begin
      norm_n = adnlp_pkg::CNT_W'(rdiff != '0);
      norm_d = adnlp_pkg::CNT_W'(rdiff == '0);
    end else begin
      norm_n = rdiff;
      norm_d = cdiff;
    end
  end

  assign sample_wr = (state == T_EVAL) && !hold_mode && window_end;
  assign cmp_start = (state == T_LOAD) && (cmp_idx != '0);
  assign busy      = (state != T_IDLE);

  // Sample store: one write port, one registered read port addressed by the compare index.
  always_ff @(posedge clk) begin
    if (sample_wr) begin
      sample_n[slot] <= norm_n;
      sample_d[slot] <= norm_d;
    end
    rd_n <= sample_n[cmp_idx];
    rd_d <= sample_d[cmp_idx];
  end

  // Shared compare unit: is the candidate's IPC strictly above the best so far.
  adnlp_xmul u_xmul (
    .clk     (clk),
    .rst     (rst),
    .start   (cmp_start),
    .bn      (rd_n),
    .bd      (rd_d),
    .an      (best_n),
    .ad      (best_d),
    .done    (cmp_done),
    .greater (cmp_greater)
  );

  // Sequencer: evaluate the tick and, after the last sampling window, scan the stored windows for the best degree.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= T_IDLE;
      mark_retired <= '0;
      mark_cycle   <= '0;
      cur_degree   <= '0;
      hold_mode    <= 1'b0;
      cmp_idx      <= '0;
      best         <= '0;
    end else begin
      case (state)
        T_IDLE: begin
          if (req.start) begin
            cyc_q <= req.cycle_now;
            ret_q <= req.retired_now;
            state <= T_EVAL;
          end
        end
        T_EVAL: begin
          if (window_end) begin
            mark_retired <= ret_q;
            mark_cycle   <= cyc_q;
            if (hold_mode) begin
              cur_degree <= '0;
              hold_mode  <= 1'b0;
              state      <= T_IDLE;
            end else if (slot < adnlp_pkg::IDX_W'(adnlp_pkg::TOP_DEGREE)) begin
              cur_degree <= adnlp_pkg::DEG_W'(slot) + adnlp_pkg::DEG_W'(1);
              state      <= T_IDLE;
            end else begin
              cmp_idx <= '0;
              state   <= T_READ;
            end
          end else begin
            state <= T_IDLE;
          end
        end
        T_READ: begin
          state <= T_LOAD;
        end
        T_LOAD: begin
          if (cmp_idx == '0) begin
            best    <= '0;
            best_n  <= rd_n;
            best_d  <= rd_d;
            cmp_idx <= adnlp_pkg::IDX_W'(1);
            state   <= T_READ;
          end else begin
            state <= T_MUL;
          end
        end
        T_MUL: begin
          if (cmp_done) begin
            if (cmp_greater) begin
              best   <= cmp_idx;
              best_n <= rd_n;
              best_d <= rd_d;
            end
            if (cmp_idx == adnlp_pkg::IDX_W'(adnlp_pkg::TOP_DEGREE)) begin
              cur_degree <= adnlp_pkg::DEG_W'(cmp_greater ? cmp_idx : best);
              hold_mode  <= 1'b1;
              state      <= T_IDLE;
            end else begin
              cmp_idx <= cmp_idx + adnlp_pkg::IDX_W'(1);
              state   <= T_READ;
            end
          end
        end
        default: begin
          state <= T_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/adnlp_emit.sv @@
// Address emitter: walks the next blocks after an access and drives the result register.
// Stops at the page boundary and flags the final address; depends on adnlp_pkg.
module adnlp_emit (
  input  logic                 clk,
  input  logic                 rst,
  input  adnlp_pkg::emit_req_t req,
  output logic                 busy,
  output logic                 out_valid,
  input  logic                 out_ready,
  output adnlp_pkg::out_t      out_data
);

  localparam int SUM_W = adnlp_pkg::ADDR_W + 1;

  logic                               active;
  logic [adnlp_pkg::ADDR_W-1:0]       base;
  logic [adnlp_pkg::EMIT_W-1:0]       deg;
  logic [adnlp_pkg::EMIT_W-1:0]       idx;

  logic [adnlp_pkg::EMIT_W-1:0]       start_deg;
  logic [adnlp_pkg::EMIT_W-1:0]       k_cur;
  logic [adnlp_pkg::EMIT_W-1:0]       k_nxt;
  logic [SUM_W-1:0]                   sum_cur;
  logic [SUM_W-1:0]                   sum_nxt;
  logic                               cur_ok;
  logic                               nxt_ok;
  logic                               cur_last;
  logic                               load;

  // Clamp the degree to the number of results one access may give.
  assign start_deg = (req.degree > adnlp_pkg::DEG_W'(adnlp_pkg::MAX_RESULTS))
                     ? adnlp_pkg::EMIT_W'(adnlp_pkg::MAX_RESULTS)
                     : adnlp_pkg::EMIT_W'(req.degree);

  // The current and the following block address; a carry out means another page.
  always_comb begin
    k_cur    = idx + adnlp_pkg::EMIT_W'(1);
    k_nxt    = idx + adnlp_pkg::EMIT_W'(2);
    sum_cur  = SUM_W'(base) + (SUM_W'(k_cur) << adnlp_pkg::BLOCK_BITS);
    sum_nxt  = SUM_W'(base) + (SUM_W'(k_nxt) << adnlp_pkg::BLOCK_BITS);
    cur_ok   = !sum_cur[SUM_W-1] && (sum_cur[adnlp_pkg::ADDR_W-1:adnlp_pkg::PAGE_BITS] ==
                                     base[adnlp_pkg::ADDR_W-1:adnlp_pkg::PAGE_BITS]);
    nxt_ok   = !sum_nxt[SUM_W-1] && (sum_nxt[adnlp_pkg::ADDR_W-1:adnlp_pkg::PAGE_BITS] ==
                                     base[adnlp_pkg::ADDR_W-1:adnlp_pkg::PAGE_BITS]);
    cur_last = (k_cur == deg) || !nxt_ok;
    load     = active && (!out_valid || out_ready);
  end

  assign busy = active;

  // Control: walk while active, one result per cycle whenever the result register is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (req.start && (start_deg != '0)) begin
        active <= 1'b1;
      end else if (load && (!cur_ok || cur_last)) begin
        active <= 1'b0;
      end
      if (load && cur_ok) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath: access address, walk position and the result register.
  always_ff @(posedge clk) begin
    if (req.start) begin
      base <= req.addr;
      deg  <= start_deg;
      idx  <= '0;
    end else if (load && cur_ok) begin
      out_data.prefetch_addr <= sum_cur[adnlp_pkg::ADDR_W-1:0];
      out_data.last          <= cur_last;
      idx                    <= k_cur;
    end
  end

endmodule

@@ rtl/adnlp_chk.sv @@
// Port-level checker for the adaptive-degree next-line prefetcher.
// Watches the top level's channels only; depends on adnlp_pkg and is bound to the top level.
module adnlp_chk (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_ready,
  input adnlp_pkg::in_t  in_data,
  input logic            out_valid,
  input logic            out_ready,
  input adnlp_pkg::out_t out_data
);

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  // A stalled result transaction holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // While a non-final address is shown, the access is still being walked.
  a_busy_midwalk: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.last |-> !in_ready)
    else $error("input taken in the middle of an access");

  // A taken non-final address is followed at once by the next block.
  a_next_block: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_data.last |=>
      out_valid && (out_data.prefetch_addr ==
                    $past(out_data.prefetch_addr) + adnlp_pkg::BLOCK_BYTES))
    else $error("next prefetch address missing or wrong");

  // A tick never starts a result.
  a_tick_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_data.cmd == adnlp_pkg::CMD_TICK) |=> !$rose(out_valid))
    else $error("tick produced a result");

endmodule

bind adaptive_degree_next_line_prefetcher_core adnlp_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
